FILE: src/bucket_index_binary_search_assert.svh
// Assertion macros for the bucket index search block
`ifndef BUCKET_INDEX_BINARY_SEARCH_ASSERT_SVH
`define BUCKET_INDEX_BINARY_SEARCH_ASSERT_SVH

// same-cycle implication, clocked on clk, idle in reset
`define BISQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, idle in reset
`define BISQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bisq_pkg.sv
// Shared types and constants for the bucket index search block
`timescale 1ns / 1ps
`default_nettype none

package bisq_pkg;

    localparam int BOUND_INDEX_W  = 8;
    localparam int BUCKET_INDEX_W = 8;
    localparam int BUCKET_COUNT_W = 9;

    typedef enum logic
    {
        OP_WRITE    = 1'b0,
        OP_CLASSIFY = 1'b1
    } op_t;

    // control part of a request travelling along the cell chain
    typedef struct packed
    {
        logic                     valid;
        op_t                      op;
        logic [BOUND_INDEX_W-1:0] bound_index;
    } ctl_t;

    localparam ctl_t CTL_IDLE = '{valid: 1'b0, op: OP_WRITE, bound_index: '0};

endpackage

`default_nettype wire

FILE: src/bisq_req_if.sv
// Request channel: bound writes and values to classify
`timescale 1ns / 1ps
`default_nettype none

interface bisq_req_if #(
    parameter int VALUE_BITS = 32
);
    logic                                   valid;
    logic                                   ready;
    bisq_pkg::op_t                          op;
    logic [bisq_pkg::BOUND_INDEX_W-1:0]     bound_index;
    logic signed [VALUE_BITS-1:0]           value;

    modport source (output valid, output op, output bound_index, output value, input ready);
    modport sink   (input valid, input op, input bound_index, input value, output ready);
endinterface

`default_nettype wire

FILE: src/bisq_resp_if.sv
// Result channel: bucket index of a classified value
`timescale 1ns / 1ps
`default_nettype none

interface bisq_resp_if;
    logic                                   valid;
    logic                                   ready;
    logic [bisq_pkg::BUCKET_INDEX_W-1:0]    bucket_index;

    modport source (output valid, output bucket_index, input ready);
    modport sink   (input valid, input bucket_index, output ready);
endinterface

`default_nettype wire

FILE: src/bisq_cfg_if.sv
// Configuration write channel: bucket count register
`timescale 1ns / 1ps
`default_nettype none

interface bisq_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [bisq_pkg::BUCKET_COUNT_W-1:0]    bucket_count;

    modport source (output valid, output bucket_count, input ready);
    modport sink   (input valid, input bucket_count, output ready);
endinterface

`default_nettype wire

FILE: src/bisq_ram.sv
// Generic single write port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none

module bisq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output      logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/bisq_cell.sv
// One search level: holds the bounds that are pivots at this level
`timescale 1ns / 1ps
`default_nettype none

module bisq_cell #(
    parameter int TABLE_DEPTH = 256,
    parameter int VALUE_BITS  = 32,
    parameter int LEVEL       = 0,
    localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int LW         = IDX_W + 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         adv,
    input  wire logic [LW-1:0]                limit,
    input  wire bisq_pkg::ctl_t               ctl_in,
    input  wire logic signed [VALUE_BITS-1:0] value_in,
    input  wire logic [IDX_W-1:0]             lo_in,
    output      bisq_pkg::ctl_t               ctl_out,
    output      logic signed [VALUE_BITS-1:0] value_out,
    output      logic [IDX_W-1:0]             lo_out
);

    localparam int S     = IDX_W - 1 - LEVEL;          // step is 2**S
    localparam int DEPTH = 1 << LEVEL;
    localparam int AW    = (LEVEL > 0) ? LEVEL : 1;
    localparam int BIW   = bisq_pkg::BOUND_INDEX_W;
    localparam int CW    = (IDX_W > BIW) ? IDX_W : BIW;
    localparam logic [IDX_W-1:0] STEP     = IDX_W'(1) << S;
    localparam logic [CW-1:0]    LOW_MASK = CW'((1 << S) - 1);
    localparam logic [CW-1:0]    MAX_IDX  = CW'(TABLE_DEPTH - 1);

    logic [CW-1:0]                widx;
    logic                         wr_hit;
    logic                         we;
    logic [IDX_W-1:0]             pivot;
    logic [VALUE_BITS-1:0]        rd_data;

    bisq_pkg::ctl_t               ctl_a_reg;
    logic signed [VALUE_BITS-1:0] value_a_reg;
    logic [IDX_W-1:0]             lo_a_reg;
    logic                         piv_ok_reg;

    bisq_pkg::ctl_t               ctl_out_reg;
    logic signed [VALUE_BITS-1:0] value_out_reg;
    logic [IDX_W-1:0]             lo_out_reg;
    logic                         ge;
    logic [IDX_W-1:0]             lo_next;

    // a bound belongs here when its lowest set bit is the step of this level
    assign widx   = CW'(ctl_in.bound_index);
    assign wr_hit = (widx <= MAX_IDX) && widx[S] && ((widx & LOW_MASK) == '0);
    assign we     = adv && ctl_in.valid && (ctl_in.op == bisq_pkg::OP_WRITE) && wr_hit;
    assign pivot  = lo_in | STEP;

    bisq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (AW'(widx >> (S + 1))),
        .wdata (value_in),
        .re    (adv),
        .raddr (AW'(pivot >> (S + 1))),
        .rdata (rd_data)
    );

    // stage A: table read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg   <= bisq_pkg::CTL_IDLE;
            ctl_out_reg <= bisq_pkg::CTL_IDLE;
        end
        else if (adv)
        begin
            ctl_a_reg   <= ctl_in;
            ctl_out_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_a_reg   <= value_in;
            lo_a_reg      <= lo_in;
            piv_ok_reg    <= {1'b0, pivot} < limit;
            value_out_reg <= value_a_reg;
            lo_out_reg    <= lo_next;
        end
    end

    // stage B: pivots past the bucket count act as bounds above the value
    assign ge      = (ctl_a_reg.op == bisq_pkg::OP_CLASSIFY) && piv_ok_reg
                     && (value_a_reg >= $signed(rd_data));
    assign lo_next = ge ? (lo_a_reg | STEP) : lo_a_reg;

    assign ctl_out   = ctl_out_reg;
    assign value_out = value_out_reg;
    assign lo_out    = lo_out_reg;

endmodule

`default_nettype wire

FILE: src/bucket_index_binary_search.sv
// Throughput: one request per cycle; the cell chain stalls only while a result waits
// in the result register and another is done. The chain has log2(TABLE_DEPTH) levels,
// each with a stage A and an output register, followed by the result register.
// Each level owns its own RAM slice, so one read per level per cycle suffices.
// Reset: bucket count 1, chain and result register empty; bound table undefined until
// written, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "bucket_index_binary_search_assert.svh"

module bucket_index_binary_search #(
    parameter int TABLE_DEPTH = 256,
    parameter int VALUE_BITS  = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bisq_cfg_if.sink    cfg,
    bisq_req_if.sink    req,
    bisq_resp_if.source resp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW    = IDX_W + 1;
    localparam int BCW   = bisq_pkg::BUCKET_COUNT_W;
    localparam int KW    = (LW > BCW) ? LW : BCW;

    logic [LW-1:0]                          limit_reg;
    logic [LW-1:0]                          limit_next;
    logic [KW-1:0]                          count_ext;

    bisq_pkg::ctl_t                         ctl_chain   [0:IDX_W];
    logic signed [VALUE_BITS-1:0]           value_chain [0:IDX_W];
    logic [IDX_W-1:0]                       lo_chain    [0:IDX_W];

    logic                                   adv;
    logic                                   last_cls;
    logic                                   resp_valid_reg;
    logic                                   resp_valid_next;
    logic [bisq_pkg::BUCKET_INDEX_W-1:0]    bucket_index_reg;

    // bucket count, clamped to 1..TABLE_DEPTH at write time
    assign cfg.ready = 1'b1;
    assign count_ext = KW'(cfg.bucket_count);

    always_comb
    begin
        priority if (count_ext == '0)
            limit_next = LW'(1);
        else if (count_ext > KW'(TABLE_DEPTH))
            limit_next = LW'(TABLE_DEPTH);
        else
            limit_next = LW'(count_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LW'(1);
        end
        else if (cfg.valid)
        begin
            limit_reg <= limit_next;
        end
    end

    assign last_cls = ctl_chain[IDX_W].valid && (ctl_chain[IDX_W].op == bisq_pkg::OP_CLASSIFY);
    assign adv      = !resp_valid_reg || resp.ready || !last_cls;
    assign req.ready = adv;

    assign ctl_chain[0].valid       = req.valid && adv;
    assign ctl_chain[0].op          = req.op;
    assign ctl_chain[0].bound_index = req.bound_index;
    assign value_chain[0]           = req.value;
    assign lo_chain[0]              = '0;

    for (genvar k = 0; k < IDX_W; k++)
    begin : g_cell
        bisq_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .VALUE_BITS  (VALUE_BITS),
            .LEVEL       (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .limit     (limit_reg),
            .ctl_in    (ctl_chain[k]),
            .value_in  (value_chain[k]),
            .lo_in     (lo_chain[k]),
            .ctl_out   (ctl_chain[k+1]),
            .value_out (value_chain[k+1]),
            .lo_out    (lo_chain[k+1])
        );
    end

    // result register: write requests leave the chain without a result
    always_comb
    begin
        resp_valid_next = resp_valid_reg && !resp.ready;
        if (adv && last_cls)
        begin
            resp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            resp_valid_reg <= resp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && last_cls)
        begin
            bucket_index_reg <= bisq_pkg::BUCKET_INDEX_W'(lo_chain[IDX_W]);
        end
    end

    assign resp.valid        = resp_valid_reg;
    assign resp.bucket_index = bucket_index_reg;

    `BISQ_ASSERT_NOW(a_limit_range, 1'b1, (limit_reg != '0) && (limit_reg <= LW'(TABLE_DEPTH)), "bucket count out of range")
    `BISQ_ASSERT_NEXT(a_limit_hold, !(cfg.valid && cfg.ready), $stable(limit_reg), "bucket count changed without a write")
    `BISQ_ASSERT_NOW(a_result_source, $rose(resp.valid), $past(adv && last_cls), "result without a finished search")
    `BISQ_ASSERT_NOW(a_ready_when_empty, !resp.valid, req.ready, "request refused with result register empty")

endmodule

`default_nettype wire
